[hw/rtl/set_assoc_cache_rrip_lru_assert.svh]
// Assertion macros for the cache replacement block.
// Used by the top level; needs clk and rst in scope.
`ifndef SET_ASSOC_CACHE_RRIP_LRU_ASSERT_SVH
`define SET_ASSOC_CACHE_RRIP_LRU_ASSERT_SVH
`define SACR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SACR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/sacr_pkg.sv]
// Shared types and codes of the cache replacement block.
// No dependencies.
package sacr_pkg;
  localparam int WAYS_DEF         = 8;
  localparam int SET_BITS_MAX_DEF = 6;
  localparam int RRPV_BITS_DEF    = 2;
  localparam int STAMP_BITS_DEF   = 32;
  localparam int SET_IDX_W        = 12;
  localparam logic [3:0] LINE_SHIFT_MAX = 4'd12;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_LOCK   = 2'd2;
  localparam logic [1:0] OP_UNLOCK = 2'd3;

  localparam logic [2:0] POL_LRU   = 3'd0;
  localparam logic [2:0] POL_RAND  = 3'd1;
  localparam logic [2:0] POL_SRRIP = 3'd2;
  localparam logic [2:0] POL_BRRIP = 3'd3;
  localparam logic [2:0] POL_FP    = 3'd4;

  localparam logic [1:0] CFG_POLICY     = 2'd0;
  localparam logic [1:0] CFG_LINE_SHIFT = 2'd1;
  localparam logic [1:0] CFG_SET_BITS   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [2:0]  lock_way;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] way_used;
    logic       writeback;
    logic       forced_evict;
  } rsp_t;

  typedef struct packed {
    logic [2:0] policy;
    logic [3:0] line_shift;
    logic [2:0] set_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [SET_IDX_W-1:0] set;
    logic [31:0]          tag;
    logic [2:0]           lock_way;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;
endpackage

[hw/rtl/set_assoc_cache_rrip_lru.sv]
// Lock/unlock go from queue to update state; read/write scan every way and, when
// random replacement evicts, take an LFSR remainder by reciprocal multiply. The back
// end takes one transaction at a time (single set memory port, way scan), starting
// when idle with its result taken. A two-entry queue decouples input acceptance.
// Reset: synchronous, clears valid bits of all rows at once, config to defaults.
module set_assoc_cache_rrip_lru #(
  parameter int WAYS         = sacr_pkg::WAYS_DEF,
  parameter int SET_BITS_MAX = sacr_pkg::SET_BITS_MAX_DEF,
  parameter int RRPV_BITS    = sacr_pkg::RRPV_BITS_DEF,
  parameter int STAMP_BITS   = sacr_pkg::STAMP_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sacr_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sacr_pkg::rsp_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [3:0]     cfg_data
);
  import sacr_pkg::*;
  `include "set_assoc_cache_rrip_lru_assert.svh"

  cfg_t   cfg;
  cmd_t   q_cmd;
  q_ctl_t q_ctl;
  logic   q_valid;
  logic   q_pop;

  assign cfg_ready   = 1'b1;
  assign q_ctl.valid = q_valid;
  assign q_ctl.pop   = q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy     <= POL_LRU;
      cfg.line_shift <= 4'd6;
      cfg.set_bits   <= 3'd6;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY:     cfg.policy     <= cfg_data[2:0];
        CFG_LINE_SHIFT: cfg.line_shift <= cfg_data;
        CFG_SET_BITS:   cfg.set_bits   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  sacr_front #(.SET_BITS_MAX(SET_BITS_MAX)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .q_pop(q_pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  sacr_back #(
    .WAYS(WAYS), .SET_BITS_MAX(SET_BITS_MAX),
    .RRPV_BITS(RRPV_BITS), .STAMP_BITS(STAMP_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_in(q_ctl), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  `SACR_ASSERT_NOW(a_pop_has_entry, q_ctl.pop, q_ctl.valid, "pop from empty queue")
  `SACR_ASSERT_NOW(a_pop_slot_free, q_ctl.pop, !out_valid, "start with result pending")
  `SACR_ASSERT_NEXT(a_taken_clears, out_valid && !out_stall, !out_valid, "result repeated")
endmodule

[hw/rtl/sacr_front.sv]
// Front end: accepts transactions, splits set and tag, queues commands.
// Depends on sacr_pkg.
module sacr_front #(
  parameter int SET_BITS_MAX = sacr_pkg::SET_BITS_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  sacr_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  sacr_pkg::req_t  in_data,
  input  logic            q_pop,
  output logic            q_valid,
  output sacr_pkg::cmd_t  q_cmd
);
  import sacr_pkg::*;

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [3:0] ls;
  logic [3:0] sb;
  logic [4:0] shamt;
  logic [31:0] mask;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    ls = (cfg.line_shift > LINE_SHIFT_MAX) ? LINE_SHIFT_MAX : cfg.line_shift;
    sb = (32'(cfg.set_bits) > SET_BITS_MAX) ? 4'(SET_BITS_MAX) : {1'b0, cfg.set_bits};
    shamt = 5'(ls) + 5'(sb);
    mask = (32'd1 << sb) - 32'd1;
    cmd.op = in_data.op;
    cmd.set = SET_IDX_W'((in_data.addr >> ls) & mask);
    cmd.tag = in_data.addr >> shamt;
    cmd.lock_way = in_data.lock_way;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

[hw/rtl/sacr_back.sv]
// Back end: set memory, way scan, victim choice, row update and result register.
// Depends on sacr_pkg.
module sacr_back #(
  parameter int WAYS         = sacr_pkg::WAYS_DEF,
  parameter int SET_BITS_MAX = sacr_pkg::SET_BITS_MAX_DEF,
  parameter int RRPV_BITS    = sacr_pkg::RRPV_BITS_DEF,
  parameter int STAMP_BITS   = sacr_pkg::STAMP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  sacr_pkg::cfg_t   cfg,
  input  sacr_pkg::q_ctl_t q_in,
  output logic             q_pop,
  input  sacr_pkg::cmd_t   q_cmd,
  output logic             out_valid,
  input  logic             out_stall,
  output sacr_pkg::rsp_t   out_data
);
  import sacr_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
  localparam int ROWS  = 1 << SET_W;
  localparam logic [RRPV_BITS-1:0] RMAX = {RRPV_BITS{1'b1}};
  localparam logic [STAMP_BITS-1:0] SMAX = {STAMP_BITS{1'b1}};
  localparam int RECIP_SH = 24;
  localparam logic [24:0] RECIP = 25'((64'd1 << RECIP_SH) / WAYS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MOD, S_UPD} state_t;

  logic [WAYS-1:0][31:0]             tag_mem   [ROWS];
  logic [WAYS-1:0][STAMP_BITS-1:0]   stamp_mem [ROWS];
  logic [WAYS-1:0][RRPV_BITS-1:0]    rrpv_mem  [ROWS];
  logic [WAYS-1:0]                   valid_mem [ROWS];
  logic [WAYS-1:0]                   dirty_mem [ROWS];
  logic [WAYS-1:0]                   lock_mem  [ROWS];
  logic [ROWS-1:0]                   row_ok;

  logic [WAYS-1:0][31:0]             rd_tag;
  logic [WAYS-1:0][STAMP_BITS-1:0]   rd_stamp;
  logic [WAYS-1:0][RRPV_BITS-1:0]    rd_rrpv;
  logic [WAYS-1:0]                   rd_valid;
  logic [WAYS-1:0]                   rd_dirty;
  logic [WAYS-1:0]                   rd_lock;
  logic                              rd_ok;

  logic [WAYS-1:0][STAMP_BITS-1:0]   cur_stamp;
  logic [WAYS-1:0][RRPV_BITS-1:0]    cur_rrpv;
  logic [WAYS-1:0]                   cur_valid;
  logic [WAYS-1:0]                   cur_dirty;
  logic [WAYS-1:0]                   cur_lock;

  logic [WAYS-1:0][31:0]             new_tag;
  logic [WAYS-1:0][STAMP_BITS-1:0]   new_stamp;
  logic [WAYS-1:0][RRPV_BITS-1:0]    new_rrpv;
  logic [WAYS-1:0][RRPV_BITS-1:0]    aged;
  logic [WAYS-1:0]                   new_valid;
  logic [WAYS-1:0]                   new_dirty;
  logic [WAYS-1:0]                   new_lock;

  state_t                state;
  cmd_t                  cmd;
  logic [SET_W-1:0]      set_idx;
  logic [WAY_W-1:0]      cnt;
  logic                  hit_f;
  logic [WAY_W-1:0]      hit_way;
  logic                  inv_f;
  logic [WAY_W-1:0]      inv_way;
  logic                  ul_f;
  logic [WAY_W-1:0]      ul_way;
  logic [STAMP_BITS-1:0] ul_stamp;
  logic [WAY_W-1:0]      all_way;
  logic [STAMP_BITS-1:0] all_stamp;
  logic [RRPV_BITS-1:0]  top;
  logic [WAY_W-1:0]      mod_r;
  logic [40:0]           rq_prod;
  logic [15:0]           rq;
  logic [15:0]           rem_raw;
  logic [15:0]           rem_fix;
  logic [15:0]           lfsr;
  logic [15:0]           lfsr_next;
  logic [4:0]            thr;
  logic [4:0]            thr_next;
  logic [STAMP_BITS-1:0] tick;
  logic [STAMP_BITS-1:0] tick_inc;

  logic                  is_rand;
  logic                  is_rrip;
  logic                  is_access;
  logic                  need_mod;
  logic                  lw_ok;
  logic [WAY_W-1:0]      lw_idx;
  logic [WAY_W-1:0]      rrip_way;
  logic [WAY_W-1:0]      sel_way;
  logic                  forced;
  logic                  wb;
  logic                  evict_rrip;
  logic                  we;
  logic                  hit_now;
  logic [RRPV_BITS:0]    age_sum;

  assign set_idx   = cmd.set[SET_W-1:0];
  assign is_rand   = (cfg.policy == POL_RAND);
  assign is_rrip   = (cfg.policy == POL_SRRIP) || (cfg.policy == POL_BRRIP) ||
                     (cfg.policy == POL_FP);
  assign is_access = (cmd.op == OP_READ) || (cmd.op == OP_WRITE);
  assign lw_ok     = (32'(cmd.lock_way) < WAYS);
  assign lw_idx    = WAY_W'(cmd.lock_way);
  assign tick_inc  = (tick != SMAX) ? tick + 1'b1 : tick;
  assign thr_next  = thr + 5'd1;
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  assign rq_prod   = 41'(lfsr) * 41'(RECIP);
  assign rq        = rq_prod[RECIP_SH +: 16];
  assign rem_raw   = lfsr - 16'(32'(rq) * WAYS);
  assign rem_fix   = (rem_raw >= 16'(WAYS)) ? rem_raw - 16'(WAYS) : rem_raw;
  assign hit_now   = cur_valid[cnt] && (rd_tag[cnt] == cmd.tag);
  assign q_pop     = (state == S_IDLE) && q_in.valid && !out_valid;

  always_comb begin
    cur_stamp = rd_ok ? rd_stamp : '0;
    cur_rrpv  = rd_ok ? rd_rrpv  : '0;
    cur_valid = rd_ok ? rd_valid : '0;
    cur_dirty = rd_ok ? rd_dirty : '0;
    cur_lock  = rd_ok ? rd_lock  : '0;
  end

  always_comb begin
    rrip_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      age_sum = {1'b0, cur_rrpv[w]} + {1'b0, RMAX - top};
      aged[w] = age_sum[RRPV_BITS] ? RMAX : age_sum[RRPV_BITS-1:0];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (aged[w] == RMAX) rrip_way = WAY_W'(w);
    end
  end

  always_comb begin
    forced     = 1'b0;
    evict_rrip = 1'b0;
    if (hit_f) begin
      sel_way = hit_way;
    end else if (inv_f) begin
      sel_way = inv_way;
    end else if (is_rand) begin
      sel_way = mod_r;
    end else if (is_rrip) begin
      sel_way = rrip_way;
      evict_rrip = is_access;
    end else if (ul_f) begin
      sel_way = ul_way;
    end else begin
      sel_way = all_way;
      forced = 1'b1;
    end
    wb = !hit_f && cur_valid[sel_way] && cur_dirty[sel_way];

    new_tag   = rd_tag;
    new_stamp = cur_stamp;
    new_rrpv  = evict_rrip ? aged : cur_rrpv;
    new_valid = cur_valid;
    new_dirty = cur_dirty;
    new_lock  = cur_lock;
    if (!is_access) begin
      if (lw_ok) new_lock[lw_idx] = (cmd.op == OP_LOCK);
    end else if (hit_f) begin
      new_stamp[sel_way] = tick_inc;
      if (cmd.op == OP_WRITE) new_dirty[sel_way] = 1'b1;
      if ((cfg.policy == POL_SRRIP) || (cfg.policy == POL_BRRIP)) begin
        new_rrpv[sel_way] = '0;
      end else if ((cfg.policy == POL_FP) && (cur_rrpv[sel_way] != '0)) begin
        new_rrpv[sel_way] = cur_rrpv[sel_way] - 1'b1;
      end
    end else begin
      new_tag[sel_way]   = cmd.tag;
      new_valid[sel_way] = 1'b1;
      new_dirty[sel_way] = (cmd.op == OP_WRITE);
      new_lock[sel_way]  = 1'b0;
      new_stamp[sel_way] = tick_inc;
      if ((cfg.policy == POL_SRRIP) || (cfg.policy == POL_FP)) begin
        new_rrpv[sel_way] = RMAX - 1'b1;
      end else if (cfg.policy == POL_BRRIP) begin
        new_rrpv[sel_way] = (thr_next == 5'd0) ? RMAX - 1'b1 : RMAX;
      end
    end
  end

  assign we       = (state == S_UPD);
  assign need_mod = !hit_f && !hit_now && !inv_f && cur_valid[cnt] && is_rand;

  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[set_idx]   <= new_tag;
      stamp_mem[set_idx] <= new_stamp;
      rrpv_mem[set_idx]  <= new_rrpv;
      valid_mem[set_idx] <= new_valid;
      dirty_mem[set_idx] <= new_dirty;
      lock_mem[set_idx]  <= new_lock;
    end
    if (q_pop) begin
      rd_tag   <= tag_mem[q_cmd.set[SET_W-1:0]];
      rd_stamp <= stamp_mem[q_cmd.set[SET_W-1:0]];
      rd_rrpv  <= rrpv_mem[q_cmd.set[SET_W-1:0]];
      rd_valid <= valid_mem[q_cmd.set[SET_W-1:0]];
      rd_dirty <= dirty_mem[q_cmd.set[SET_W-1:0]];
      rd_lock  <= lock_mem[q_cmd.set[SET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_ok    <= '0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
      tick      <= '0;
      lfsr      <= 16'hACE1;
      thr       <= 5'd0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd   <= q_cmd;
            rd_ok <= row_ok[q_cmd.set[SET_W-1:0]];
            cnt   <= '0;
            hit_f <= 1'b0;
            inv_f <= 1'b0;
            ul_f  <= 1'b0;
            top   <= '0;
            state <= ((q_cmd.op == OP_READ) || (q_cmd.op == OP_WRITE)) ? S_SCAN : S_UPD;
          end
        end
        S_SCAN: begin
          if (!hit_f && hit_now) begin
            hit_f   <= 1'b1;
            hit_way <= cnt;
          end
          if (!inv_f && !cur_valid[cnt]) begin
            inv_f   <= 1'b1;
            inv_way <= cnt;
          end
          if (!cur_lock[cnt] && (!ul_f || (cur_stamp[cnt] < ul_stamp))) begin
            ul_f     <= 1'b1;
            ul_way   <= cnt;
            ul_stamp <= cur_stamp[cnt];
          end
          if ((cnt == '0) || (cur_stamp[cnt] < all_stamp)) begin
            all_way   <= cnt;
            all_stamp <= cur_stamp[cnt];
          end
          if (cur_rrpv[cnt] > top) top <= cur_rrpv[cnt];
          cnt <= cnt + 1'b1;
          if (cnt == WAY_W'(WAYS - 1)) begin
            if (need_mod) begin
              lfsr  <= lfsr_next;
              state <= S_MOD;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_MOD: begin
          mod_r <= WAY_W'(rem_fix);
          state <= S_UPD;
        end
        S_UPD: begin
          row_ok[set_idx] <= 1'b1;
          out_valid <= 1'b1;
          if (is_access) begin
            tick <= tick_inc;
            if (!hit_f && (cfg.policy == POL_BRRIP)) thr <= thr_next;
            out_data.hit          <= hit_f;
            out_data.way_used     <= 3'({3'b000, sel_way});
            out_data.writeback    <= wb;
            out_data.forced_evict <= !hit_f && !inv_f && forced;
          end else begin
            out_data.hit          <= 1'b0;
            out_data.way_used     <= cmd.lock_way;
            out_data.writeback    <= 1'b0;
            out_data.forced_evict <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
